[design/sector_cache_slot_manager_assert.svh]
// Assertion macros for the sector cache slot manager.
// Included by the top level; expects clk and rst_n in scope.
`ifndef SECTOR_CACHE_SLOT_MANAGER_ASSERT_SVH
`define SECTOR_CACHE_SLOT_MANAGER_ASSERT_SVH

// Same-cycle implication, gated by reset
`define SCSM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, gated by reset
`define SCSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/scsm_pkg.sv]
// Shared types, codes and constants of the sector cache slot manager.
// No dependencies.
`default_nettype none
package scsm_pkg;

  // Function codes of an input beat
  localparam logic [1:0] FN_FETCH = 2'd0;
  localparam logic [1:0] FN_SAVE  = 2'd1;
  localparam logic [1:0] FN_ERASE = 2'd2;
  localparam logic [1:0] FN_BAD   = 2'd3;

  // Result action codes
  localparam logic [2:0] ACT_MISS  = 3'd0;
  localparam logic [2:0] ACT_READ  = 3'd1;
  localparam logic [2:0] ACT_WRITE = 3'd2;
  localparam logic [2:0] ACT_COPY  = 3'd3;
  localparam logic [2:0] ACT_DONE  = 3'd4;
  localparam logic [2:0] ACT_ERROR = 3'd5;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] CFG_CACHE_ON  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROT_ON   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_LINES = 2'd2;

  // Hash and remainder unit
  localparam int          DL_W          = 13;
  localparam logic [31:0] HASH_MULT     = 32'd2630849305;
  localparam int          BITS_PER_STEP = 4;
  localparam int          HASH_STEPS    = 64 / BITS_PER_STEP;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] sector;
    logic [15:0] owner;
    logic        is_dir;
    logic [1:0]  indirection;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  action;
    logic        store_area;
    logic [11:0] slot;
    logic [5:0]  from_slot;
    logic        last;
  } out_beat_t;

  // One protected entry
  typedef struct packed {
    logic [15:0] sector;
    logic [15:0] owner;
    logic        dir;
    logic [1:0]  level;
  } entry_t;

  // Per-cell control
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  function automatic out_beat_t mk_out(logic [2:0] act, logic area, logic [11:0] slot,
                                       logic [5:0] from, logic last);
    out_beat_t o;
    o.action     = act;
    o.store_area = area;
    o.slot       = slot;
    o.from_slot  = from;
    o.last       = last;
    return o;
  endfunction

endpackage
`default_nettype wire

[design/scsm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module scsm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[design/scsm_cell.sv]
// One protected-area cell: holds an entry, shifts it to its neighbor or loads it.
// Depends on scsm_pkg.
`default_nettype none
module scsm_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire scsm_pkg::cell_ctl_t ctl,
  input  wire scsm_pkg::entry_t  nbr,
  input  wire scsm_pkg::entry_t  ld,
  output scsm_pkg::entry_t       q
);
  import scsm_pkg::*;

  entry_t ent_r;

  // load wins over shift; the two never coincide
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else if (ctl.load) begin
      ent_r <= ld;
    end else if (ctl.shift) begin
      ent_r <= nbr;
    end
  end

  assign q = ent_r;

endmodule
`default_nettype wire

[design/scsm_hash.sv]
// Sector hash: (key-1)*HASH_MULT mod 2^64, then remainder by the line count,
// four dividend bits per cycle. Depends on scsm_pkg.
`default_nettype none
module scsm_hash (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [15:0]     key,
  input  wire logic [12:0]     n,
  output logic                 done,
  output logic      [12:0]     rem
);
  import scsm_pkg::*;

  logic [63:0] prod_r;
  logic [12:0] rem_r;
  logic [3:0]  cnt_r;
  logic        run_r;
  logic        done_r;
  logic [15:0] km1;
  logic [47:0] mul;
  logic [63:0] prod_init;
  logic [12:0] rem_step;

  // sector 0 wraps to 2^64-1, whose product is -HASH_MULT mod 2^64
  assign km1       = key - 16'd1;
  assign mul       = {32'd0, km1} * {16'd0, HASH_MULT};
  assign prod_init = (key == 16'd0) ? (64'd0 - {32'd0, HASH_MULT}) : {16'd0, mul};

  // restoring remainder, several bits per cycle
  always_comb begin
    logic [13:0] t;
    logic [12:0] r;
    r = rem_r;
    for (int j = 0; j < BITS_PER_STEP; j++) begin
      t = {r, prod_r[63-j]};
      if (t >= {1'b0, n}) begin
        t = t - {1'b0, n};
      end
      r = t[12:0];
    end
    rem_step = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'(HASH_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= prod_init;
      rem_r  <= '0;
    end else if (run_r) begin
      prod_r <= prod_r << BITS_PER_STEP;
      rem_r  <= rem_step;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

[design/sector_cache_slot_manager.sv]
// Sector cache slot manager: direct tag RAM, protected ring of cells, control.
// Depends on scsm_pkg, scsm_ram, scsm_cell, scsm_hash and the assertion header.
//
// A command is taken when start is high and busy low; each result appears on
// out_data for one cycle with out_valid and cannot be held off. After reset
// the direct tag RAM is cleared, one line a cycle, with busy high. Unknown
// functions, fetches and saves with the cache off, and erases with the
// protected area off are answered straight from idle. Every hash is one
// multiply, then a remainder unit taking four bits a cycle. A fetch reads the
// tag RAM after its hash and, on a direct miss with the protected area on,
// scans the protected ring, which rotates one entry past the head cell each
// cycle. A save with the protected area on scans the ring first, then adds a
// hash when it falls back to the direct area, or a hash and an extra write
// state when it evicts; an eviction gives two results on consecutive cycles.
`default_nettype none
`include "sector_cache_slot_manager_assert.svh"
module sector_cache_slot_manager #(
  parameter int PROTECTED_ENTRIES = 36,
  parameter int MAX_DIRECT_LINES  = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire scsm_pkg::in_beat_t            in_data,
  output logic                               out_valid,
  output scsm_pkg::out_beat_t                out_data,
  input  wire logic                          cfg_we,
  input  wire logic [scsm_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [scsm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import scsm_pkg::*;

  localparam int LW = $clog2(MAX_DIRECT_LINES);
  localparam int IW = (PROTECTED_ENTRIES > 1) ? $clog2(PROTECTED_ENTRIES) : 1;
  localparam logic [DL_W-1:0] MAX_DL =
    (MAX_DIRECT_LINES > 8191) ? 13'h1fff : DL_W'(MAX_DIRECT_LINES);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_HASH   = 7'b0000100,
    S_RDCMP  = 7'b0001000,
    S_SCAN   = 7'b0010000,
    S_DECIDE = 7'b0100000,
    S_EMIT2  = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    PUR_FETCH = 2'd0,
    PUR_SAVE  = 2'd1,
    PUR_EVICT = 2'd2
  } pur_t;

  // configuration
  logic            cache_on_r, prot_on_r;
  logic [DL_W-1:0] dlines_r;
  logic [DL_W-1:0] n_eff;

  // control
  state_t state_r, state_nxt;
  pur_t   pur_r, pur_nxt;
  logic [LW-1:0] clr_r, clr_nxt;
  logic [IW-1:0] scnt_r, scnt_nxt;
  logic [IW-1:0] e_r, e_nxt;

  // captured command
  in_beat_t cmd_r;

  // scan results
  logic          fnd_s_r, fnd_a_r, fnd_b_r, fnd_c_r, fnd_d_r;
  logic          fnd_s_nxt, fnd_a_nxt, fnd_b_nxt, fnd_c_nxt, fnd_d_nxt;
  logic [IW-1:0] idx_s_r, idx_a_r, idx_b_r, idx_c_r, idx_d_r;
  logic [IW-1:0] idx_s_nxt, idx_a_nxt, idx_b_nxt, idx_c_nxt, idx_d_nxt;
  logic [15:0]   evsec_r, evsec_nxt;

  // output register
  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_r, out_nxt;

  // hash unit
  logic        hash_start, hash_done;
  logic [15:0] hash_key;
  logic [12:0] hash_rem;

  // tag RAM
  logic          ram_we;
  logic [LW-1:0] ram_waddr, line_addr;
  logic [15:0]   ram_wdata, ram_rdata;

  // protected ring
  entry_t    cell_q [PROTECTED_ENTRIES];
  entry_t    head, feed, ld_ent;
  logic      shift, load_en;
  logic [IW-1:0] load_idx;

  // effective line count
  always_comb begin
    if (dlines_r == '0) begin
      n_eff = 13'd1;
    end else if (dlines_r > MAX_DL) begin
      n_eff = MAX_DL;
    end else begin
      n_eff = dlines_r;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cache_on_r <= 1'b0;
      prot_on_r  <= 1'b0;
      dlines_r   <= 13'd1;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_CACHE_ON:  cache_on_r <= cfg_wdata[0];
        CFG_PROT_ON:   prot_on_r  <= cfg_wdata[0];
        CFG_DIR_LINES: dlines_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  scsm_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (hash_key),
    .n     (n_eff),
    .done  (hash_done),
    .rem   (hash_rem)
  );

  assign line_addr = LW'(hash_rem);

  scsm_ram #(.WIDTH(16), .DEPTH(MAX_DIRECT_LINES)) u_tags (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (line_addr),
    .rdata (ram_rdata)
  );

  // ring: head is cell 0, tail takes the head back, erase clears owner on the way
  assign head = cell_q[0];
  always_comb begin
    feed = head;
    if (state_r == S_SCAN && cmd_r.func == FN_ERASE && head.owner == cmd_r.owner) begin
      feed.owner = '0;
    end
  end

  assign ld_ent = '{sector: cmd_r.sector, owner: cmd_r.owner,
                    dir: cmd_r.is_dir, level: cmd_r.indirection};

  for (genvar i = 0; i < PROTECTED_ENTRIES; i++) begin : g_cell
    cell_ctl_t ctl;
    entry_t    nbr;
    assign ctl.shift = shift;
    assign ctl.load  = load_en && (load_idx == IW'(i));
    if (i == PROTECTED_ENTRIES - 1) begin : g_tail
      assign nbr = feed;
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end
    scsm_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .nbr   (nbr),
      .ld    (ld_ent),
      .q     (cell_q[i])
    );
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    pur_nxt       = pur_r;
    clr_nxt       = clr_r;
    scnt_nxt      = scnt_r;
    e_nxt         = e_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    hash_start    = 1'b0;
    hash_key      = in_data.sector;
    ram_we        = 1'b0;
    ram_waddr     = line_addr;
    ram_wdata     = cmd_r.sector;
    shift         = 1'b0;
    load_en       = 1'b0;
    load_idx      = e_r;
    fnd_s_nxt = fnd_s_r; fnd_a_nxt = fnd_a_r; fnd_b_nxt = fnd_b_r;
    fnd_c_nxt = fnd_c_r; fnd_d_nxt = fnd_d_r;
    idx_s_nxt = idx_s_r; idx_a_nxt = idx_a_r; idx_b_nxt = idx_b_r;
    idx_c_nxt = idx_c_r; idx_d_nxt = idx_d_r;
    evsec_nxt = evsec_r;

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == LW'(MAX_DIRECT_LINES - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        scnt_nxt  = '0;
        fnd_s_nxt = 1'b0; fnd_a_nxt = 1'b0; fnd_b_nxt = 1'b0;
        fnd_c_nxt = 1'b0; fnd_d_nxt = 1'b0;
        if (start) begin
          case (in_data.func)
            FN_FETCH: begin
              if (!cache_on_r) begin
                out_valid_nxt = 1'b1;
                out_nxt       = mk_out(ACT_ERROR, 1'b0, '0, '0, 1'b1);
              end else begin
                hash_start = 1'b1;
                pur_nxt    = PUR_FETCH;
                state_nxt  = S_HASH;
              end
            end
            FN_SAVE: begin
              if (!cache_on_r) begin
                out_valid_nxt = 1'b1;
                out_nxt       = mk_out(ACT_DONE, 1'b0, '0, '0, 1'b1);
              end else if (prot_on_r) begin
                state_nxt = S_SCAN;
              end else begin
                hash_start = 1'b1;
                pur_nxt    = PUR_SAVE;
                state_nxt  = S_HASH;
              end
            end
            FN_ERASE: begin
              if (cache_on_r && prot_on_r) begin
                state_nxt = S_SCAN;
              end else begin
                out_valid_nxt = 1'b1;
                out_nxt       = mk_out(ACT_DONE, 1'b0, '0, '0, 1'b1);
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_nxt       = mk_out(ACT_ERROR, 1'b0, '0, '0, 1'b1);
            end
          endcase
        end
      end

      S_HASH: begin
        if (hash_done) begin
          case (pur_r)
            PUR_FETCH: state_nxt = S_RDCMP;
            PUR_SAVE: begin
              ram_we        = 1'b1;
              out_valid_nxt = 1'b1;
              out_nxt       = mk_out(ACT_WRITE, 1'b0, hash_rem[11:0], '0, 1'b1);
              state_nxt     = S_IDLE;
            end
            default: begin
              // eviction: copy evicted entry to its direct line
              ram_we        = 1'b1;
              ram_wdata     = evsec_r;
              out_valid_nxt = 1'b1;
              out_nxt       = mk_out(ACT_COPY, 1'b0, hash_rem[11:0], 6'(e_r), 1'b0);
              state_nxt     = S_EMIT2;
            end
          endcase
        end
      end

      S_RDCMP: begin
        if (ram_rdata == cmd_r.sector) begin
          out_valid_nxt = 1'b1;
          out_nxt       = mk_out(ACT_READ, 1'b0, hash_rem[11:0], '0, 1'b1);
          state_nxt     = S_IDLE;
        end else if (prot_on_r) begin
          state_nxt = S_SCAN;
        end else begin
          out_valid_nxt = 1'b1;
          out_nxt       = mk_out(ACT_MISS, 1'b0, '0, '0, 1'b1);
          state_nxt     = S_IDLE;
        end
      end

      S_SCAN: begin
        // head holds entry scnt_r; record first match of each rule
        shift    = 1'b1;
        scnt_nxt = scnt_r + 1'b1;
        if (!fnd_s_r && head.sector == cmd_r.sector) begin
          fnd_s_nxt = 1'b1; idx_s_nxt = scnt_r;
        end
        if (!fnd_a_r && head.owner == cmd_r.owner && head.level == 2'd1) begin
          fnd_a_nxt = 1'b1; idx_a_nxt = scnt_r;
        end
        if (!fnd_b_r && (head.owner == '0 || !head.dir)) begin
          fnd_b_nxt = 1'b1; idx_b_nxt = scnt_r;
        end
        if (!fnd_c_r && (head.owner == '0 || (!head.dir && head.owner != cmd_r.owner))) begin
          fnd_c_nxt = 1'b1; idx_c_nxt = scnt_r;
        end
        if (!fnd_d_r && head.level == 2'd1) begin
          fnd_d_nxt = 1'b1; idx_d_nxt = scnt_r; evsec_nxt = head.sector;
        end
        if (scnt_r == IW'(PROTECTED_ENTRIES - 1)) begin
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        state_nxt = S_IDLE;
        case (cmd_r.func)
          FN_FETCH: begin
            out_valid_nxt = 1'b1;
            out_nxt = fnd_s_r ? mk_out(ACT_READ, 1'b1, 12'(idx_s_r), '0, 1'b1)
                              : mk_out(ACT_MISS, 1'b0, '0, '0, 1'b1);
          end
          FN_ERASE: begin
            out_valid_nxt = 1'b1;
            out_nxt       = mk_out(ACT_DONE, 1'b0, '0, '0, 1'b1);
          end
          FN_SAVE: begin
            if ((cmd_r.is_dir && (fnd_a_r || fnd_b_r)) || (!cmd_r.is_dir && fnd_c_r)) begin
              load_en  = 1'b1;
              load_idx = cmd_r.is_dir ? (fnd_a_r ? idx_a_r : idx_b_r) : idx_c_r;
              out_valid_nxt = 1'b1;
              out_nxt  = mk_out(ACT_WRITE, 1'b1, 12'(load_idx), '0, 1'b1);
            end else if (fnd_d_r) begin
              e_nxt      = idx_d_r;
              hash_key   = evsec_r;
              hash_start = 1'b1;
              pur_nxt    = PUR_EVICT;
              state_nxt  = S_HASH;
            end else begin
              hash_key   = cmd_r.sector;
              hash_start = 1'b1;
              pur_nxt    = PUR_SAVE;
              state_nxt  = S_HASH;
            end
          end
          default: begin
            out_valid_nxt = 1'b1;
            out_nxt       = mk_out(ACT_ERROR, 1'b0, '0, '0, 1'b1);
          end
        endcase
      end

      S_EMIT2: begin
        load_en       = 1'b1;
        out_valid_nxt = 1'b1;
        out_nxt       = mk_out(ACT_WRITE, 1'b1, 12'(e_r), '0, 1'b1);
        state_nxt     = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      pur_r       <= PUR_FETCH;
      clr_r       <= '0;
      scnt_r      <= '0;
      out_valid_r <= 1'b0;
      fnd_s_r <= 1'b0; fnd_a_r <= 1'b0; fnd_b_r <= 1'b0;
      fnd_c_r <= 1'b0; fnd_d_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pur_r       <= pur_nxt;
      clr_r       <= clr_nxt;
      scnt_r      <= scnt_nxt;
      out_valid_r <= out_valid_nxt;
      fnd_s_r <= fnd_s_nxt; fnd_a_r <= fnd_a_nxt; fnd_b_r <= fnd_b_nxt;
      fnd_c_r <= fnd_c_nxt; fnd_d_r <= fnd_d_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      cmd_r <= in_data;
    end
    e_r     <= e_nxt;
    out_r   <= out_nxt;
    idx_s_r <= idx_s_nxt; idx_a_r <= idx_a_nxt; idx_b_r <= idx_b_nxt;
    idx_c_r <= idx_c_nxt; idx_d_r <= idx_d_nxt;
    evsec_r <= evsec_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  `SCSM_ASSERT_NEXT(a_copy_then_write, out_valid && out_data.action == ACT_COPY,
    out_valid && out_data.action == ACT_WRITE && out_data.store_area && out_data.last,
    "copy beat not followed by protected write")
  `SCSM_ASSERT_SAME(a_only_copy_not_last, out_valid && !out_data.last,
    out_data.action == ACT_COPY, "non-final beat that is not a copy")
  `SCSM_ASSERT_NEXT(a_bad_func_error, start && !busy && in_data.func == FN_BAD,
    out_valid && out_data.action == ACT_ERROR && out_data.last,
    "unknown function did not give an error beat")

endmodule
`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for sector_cache_slot_manager: directed table, then random beats.
// Depends on scsm_pkg and the block's RTL; holds its own tag and entry model.
`default_nettype none
module testbench;
  import scsm_pkg::*;

  localparam int NPROT    = 36;
  localparam int NLINES   = 4096;
  localparam int N_RANDOM = 1730;

  logic      clk, rst_n, start, busy, out_valid, cfg_we;
  in_beat_t  in_data;
  out_beat_t out_data;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sector_cache_slot_manager i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // Mirror of the cache tags and settings
  logic [15:0] tag_mem[NLINES];
  logic [15:0] ent_sector[NPROT];
  logic [15:0] ent_owner[NPROT];
  logic        ent_dir[NPROT];
  logic [1:0]  ent_level[NPROT];
  logic        m_cache_on, m_prot_on;
  logic [12:0] m_lines;

  out_beat_t pending_results[$];
  int errors = 0;
  int n_copy = 0, n_read_prot = 0, n_read_direct = 0, n_miss = 0, n_direct_fallback = 0;
  int n_beats = 0;
  int sender_idle_pct = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit
  initial begin
    #(12 * 3000000);
    $display("Timeout: results still pending %0d", pending_results.size());
    $display("Verification failed");
    $finish;
  end

  task automatic report(string what, out_beat_t got, out_beat_t want);
    errors++;
    $display("MISMATCH %s: got act=%0d area=%0d slot=%0d from=%0d last=%0d, want act=%0d area=%0d slot=%0d from=%0d last=%0d",
             what, got.action, got.store_area, got.slot, got.from_slot, got.last,
             want.action, want.store_area, want.slot, want.from_slot, want.last);
  endtask

  function automatic out_beat_t beat_of(logic [2:0] act, logic area, logic [11:0] slot,
                                        logic [5:0] from, logic last);
    out_beat_t o;
    o = '{action: act, store_area: area, slot: slot, from_slot: from, last: last};
    return o;
  endfunction

  // Direct line of a sector: 64-bit wrapped hash, remainder by clamped line count
  function automatic logic [11:0] hash_line(logic [15:0] sec);
    logic [63:0] n, h;
    n = {51'd0, m_lines};
    if (n == 0) n = 1;
    if (n > NLINES) n = NLINES;
    h = ({48'd0, sec} - 64'd1) * 64'd2630849305;
    return 12'(h % n);
  endfunction

  // Protected entry choice for a save; -1 when nothing fits
  function automatic int pick_entry(logic [15:0] own, logic dir, output logic evict);
    evict = 1'b0;
    if (dir) begin
      for (int i = 0; i < NPROT; i++)
        if (ent_owner[i] == own && ent_level[i] == 2'd1) return i;
      for (int i = 0; i < NPROT; i++)
        if (ent_owner[i] == 16'd0 || !ent_dir[i]) return i;
    end else begin
      for (int i = 0; i < NPROT; i++)
        if (ent_owner[i] == 16'd0 || (!ent_dir[i] && ent_owner[i] != own)) return i;
    end
    for (int i = 0; i < NPROT; i++)
      if (ent_level[i] == 2'd1) begin
        evict = 1'b1;
        return i;
      end
    return -1;
  endfunction

  // Update the mirror for one accepted beat and queue its results
  function automatic void predict_results(in_beat_t b);
    logic [11:0] ln;
    logic        ev;
    int          e;
    case (b.func)
      FN_FETCH: begin
        if (!m_cache_on) begin
          pending_results.push_back(beat_of(ACT_ERROR, 0, 0, 0, 1));
          return;
        end
        ln = hash_line(b.sector);
        if (tag_mem[ln] == b.sector) begin
          n_read_direct++;
          pending_results.push_back(beat_of(ACT_READ, 0, ln, 0, 1));
          return;
        end
        if (m_prot_on)
          for (int i = 0; i < NPROT; i++)
            if (ent_sector[i] == b.sector) begin
              n_read_prot++;
              pending_results.push_back(beat_of(ACT_READ, 1, 12'(i), 0, 1));
              return;
            end
        n_miss++;
        pending_results.push_back(beat_of(ACT_MISS, 0, 0, 0, 1));
      end
      FN_SAVE: begin
        if (!m_cache_on) begin
          pending_results.push_back(beat_of(ACT_DONE, 0, 0, 0, 1));
          return;
        end
        if (m_prot_on) begin
          e = pick_entry(b.owner, b.is_dir, ev);
          if (e >= 0) begin
            if (ev) begin
              ln = hash_line(ent_sector[e]);
              tag_mem[ln] = ent_sector[e];
              n_copy++;
              pending_results.push_back(beat_of(ACT_COPY, 0, ln, 6'(e), 0));
            end
            ent_sector[e] = b.sector;
            ent_owner[e]  = b.owner;
            ent_dir[e]    = b.is_dir;
            ent_level[e]  = b.indirection;
            pending_results.push_back(beat_of(ACT_WRITE, 1, 12'(e), 0, 1));
            return;
          end
          n_direct_fallback++;
        end
        ln = hash_line(b.sector);
        tag_mem[ln] = b.sector;
        pending_results.push_back(beat_of(ACT_WRITE, 0, ln, 0, 1));
      end
      FN_ERASE: begin
        if (m_cache_on && m_prot_on)
          for (int i = 0; i < NPROT; i++)
            if (ent_owner[i] == b.owner) ent_owner[i] = 16'd0;
        pending_results.push_back(beat_of(ACT_DONE, 0, 0, 0, 1));
      end
      default: pending_results.push_back(beat_of(ACT_ERROR, 0, 0, 0, 1));
    endcase
  endfunction

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", out_data, '0);
      end else begin
        if (out_data !== pending_results[0]) report("result", out_data, pending_results[0]);
        void'(pending_results.pop_front());
      end
    end
  end

  // Wait for every result, then let the block settle before touching registers
  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges; block must be idle
  task automatic write_regs(logic on, logic prot, logic [12:0] lines);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_CACHE_ON;
    cfg_wdata <= {12'd0, on};
    @(posedge clk);
    cfg_idx   <= CFG_PROT_ON;
    cfg_wdata <= {12'd0, prot};
    @(posedge clk);
    cfg_idx   <= CFG_DIR_LINES;
    cfg_wdata <= lines;
    @(posedge clk);
    cfg_we    <= 1'b0;
    m_cache_on = on;
    m_prot_on  = prot;
    m_lines    = lines;
  endtask

  // Drive one beat until accepted; start stays high on return
  task automatic send_beat(in_beat_t b);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    in_data <= b;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    predict_results(b);
    n_beats++;
  endtask

  // Mostly a small pool of sectors and owners, so hits and evictions happen
  function automatic in_beat_t random_beat();
    in_beat_t b;
    int r;
    r = $urandom_range(99);
    b.func = (r < 45) ? FN_FETCH : (r < 85) ? FN_SAVE : (r < 95) ? FN_ERASE : FN_BAD;
    b.sector = ($urandom_range(99) < 85) ? 16'($urandom_range(47)) : 16'($urandom_range(65535));
    b.owner  = ($urandom_range(99) < 80) ? 16'($urandom_range(5)) : 16'($urandom_range(65535));
    b.is_dir = 1'($urandom_range(1));
    b.indirection = ($urandom_range(1) == 1) ? 2'd1 : 2'($urandom_range(3));
    return b;
  endfunction

  // Directed rows: register set, beat, and a typed result where one is obvious
  typedef struct {
    int        cfg_set;
    in_beat_t  beat;
    logic      typed;
    out_beat_t want;
  } dir_row_t;

  dir_row_t rows[$];

  function automatic void add_row(int cs, logic [1:0] f, logic [15:0] s, logic [15:0] o,
                                  logic d, logic [1:0] l, logic typed, out_beat_t w);
    dir_row_t r;
    r.cfg_set = cs;
    r.beat = '{func: f, sector: s, owner: o, is_dir: d, indirection: l};
    r.typed = typed;
    r.want = w;
    rows.push_back(r);
  endfunction

  initial begin
    logic [12:0] rnd_lines;
    int cur_set;
    int phase_len;
    logic [12:0] line_sets[8];
    logic        on_sets[8];
    logic        prot_sets[8];

    rst_n = 1'b0; start = 1'b0; in_data = '0; cfg_we = 1'b0; cfg_idx = '0; cfg_wdata = '0;
    foreach (tag_mem[i]) tag_mem[i] = '0;
    for (int i = 0; i < NPROT; i++) begin
      ent_sector[i] = '0; ent_owner[i] = '0; ent_dir[i] = 1'b0; ent_level[i] = '0;
    end
    m_cache_on = 1'b0; m_prot_on = 1'b0; m_lines = 13'd1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);

    // Set 0 is the reset state (cache off); 1 direct only; 2 protected on
    add_row(0, FN_FETCH, 16'h0000, 16'h0000, 0, 0, 1, beat_of(ACT_ERROR, 0, 0, 0, 1));
    add_row(0, FN_SAVE,  16'hffff, 16'hffff, 1, 3, 1, beat_of(ACT_DONE, 0, 0, 0, 1));
    add_row(0, FN_ERASE, 16'h0000, 16'h0000, 0, 0, 1, beat_of(ACT_DONE, 0, 0, 0, 1));
    add_row(0, FN_BAD,   16'hffff, 16'hffff, 1, 3, 1, beat_of(ACT_ERROR, 0, 0, 0, 1));
    // Zeroed tags let sector 0 hit
    add_row(1, FN_FETCH, 16'h0000, 16'h0000, 0, 0, 1, beat_of(ACT_READ, 0, 0, 0, 1));
    add_row(1, FN_FETCH, 16'hffff, 16'h0000, 0, 0, 1, beat_of(ACT_MISS, 0, 0, 0, 1));
    add_row(1, FN_SAVE,  16'hffff, 16'h0001, 0, 1, 1, beat_of(ACT_WRITE, 0, 0, 0, 1));
    add_row(1, FN_FETCH, 16'hffff, 16'h0000, 0, 0, 1, beat_of(ACT_READ, 0, 0, 0, 1));
    add_row(1, FN_BAD,   16'h0000, 16'h0000, 0, 0, 1, beat_of(ACT_ERROR, 0, 0, 0, 1));
    add_row(2, FN_SAVE,  16'd10, 16'd1, 0, 1, 0, '0);
    add_row(2, FN_SAVE,  16'd11, 16'd1, 1, 1, 0, '0);
    add_row(2, FN_SAVE,  16'd12, 16'd1, 1, 0, 0, '0);
    add_row(2, FN_SAVE,  16'd13, 16'd2, 0, 2, 0, '0);
    add_row(2, FN_FETCH, 16'd12, 16'd0, 0, 0, 0, '0);
    add_row(2, FN_FETCH, 16'd10, 16'd0, 0, 0, 0, '0);
    add_row(2, FN_ERASE, 16'd0,  16'd1, 0, 0, 1, beat_of(ACT_DONE, 0, 0, 0, 1));
    // Erased entries still hit on sector
    add_row(2, FN_FETCH, 16'd10, 16'd0, 0, 0, 0, '0);
    add_row(2, FN_SAVE,  16'h8000, 16'hffff, 1, 3, 0, '0);
    add_row(2, FN_FETCH, 16'd999, 16'd0, 0, 0, 0, '0);

    cur_set = 0;
    foreach (rows[k]) begin
      if (rows[k].cfg_set != cur_set) begin
        start <= 1'b0;
        drain();
        cur_set = rows[k].cfg_set;
        if (cur_set == 1) write_regs(1'b1, 1'b0, 13'd1);
        else write_regs(1'b1, 1'b1, 13'd4096);
      end
      send_beat(rows[k].beat);
      if (rows[k].typed) begin
        void'(pending_results.pop_back());
        pending_results.push_back(rows[k].want);
      end
    end

    // Random phases over register extremes and a few ordinary settings
    rnd_lines = 13'($urandom_range(2, 4095));
    line_sets = '{13'd4096, 13'd0, 13'd16, 13'd7, 13'd8191, 13'd1, rnd_lines, 13'd8191};
    on_sets   = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
    prot_sets = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
    phase_len = N_RANDOM / 8;
    for (int p = 0; p < 8; p++) begin
      start <= 1'b0;
      drain();
      write_regs(on_sets[p], prot_sets[p], line_sets[p]);
      for (int k = 0; k < phase_len; k++) begin
        int idx;
        idx = p * phase_len + k;
        sender_idle_pct = (idx < N_RANDOM / 3) ? 24 : (idx < 2 * N_RANDOM / 3) ? 75 : 0;
        // Hold off once until every result is back
        if (idx == 300) begin
          start <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
          @(posedge clk);
        end
        send_beat(random_beat());
      end
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Covered %0d beats over 10 register settings: %0d direct reads, %0d protected reads,",
             n_beats, n_read_direct, n_read_prot);
    $display("  %0d misses, %0d evicting copies, %0d saves falling back to the direct area",
             n_miss, n_copy, n_direct_fallback);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
+incdir+design
design/scsm_pkg.sv
design/scsm_ram.sv
design/scsm_cell.sv
design/scsm_hash.sv
design/sector_cache_slot_manager.sv
dv/testbench.sv
